/* hw/rtl/wpr_pkg.sv */
package wpr_pkg;

  // Field and storage widths
  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 24;
  localparam int CH_W        = 6;
  localparam int POS_W       = 4;
  localparam int SIZE_W      = 5;
  localparam int CHCNT_W     = 7;
  localparam int DEN_W       = 9;
  localparam int DIVCNT_W    = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Size limits and reset values of the configuration registers
  localparam int CHANS_MAX   = 64;
  localparam int WIN_MAX     = 16;
  localparam logic [SIZE_W-1:0]  ROWS_RST  = 5'd2;
  localparam logic [SIZE_W-1:0]  COLS_RST  = 5'd2;
  localparam logic [CHCNT_W-1:0] CHANS_RST = 7'd1;

  // Pooling mode codes
  localparam logic MODE_MEAN = 1'b0;
  localparam logic MODE_MAX  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_COLS  = 2'd2,
    CFG_CHANS = 2'd3
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic rd;
    logic upd;
    logic div_start;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
    logic mean;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/wpr_div.sv */
module wpr_div import wpr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ACC_W-1:0]    dividend,
  input  logic [DEN_W-1:0]    divisor,
  output logic                done,
  output logic [SAMPLE_W-1:0] quotient
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIVCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [ACC_W-1:0]    quo_r, quo_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;
  logic [ACC_W-1:0]    mag;
  logic [ACC_W-1:0]    q_signed;

  // Magnitude of the signed dividend; the most negative value maps correctly.
  assign mag   = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign diff  = trial - {1'b0, den_r};

  // One restoring division step per cycle, quotient bits shift in at the bottom.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = mag;
      den_nxt  = divisor;
      neg_nxt  = dividend[ACC_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIVCNT_W'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // Truncation toward zero: restore the sign on the magnitude quotient.
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign done     = done_r;

endmodule

/* hw/rtl/wpr_dp.sv */
module wpr_dp import wpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // Configuration registers
  logic               mode_r;
  logic [SIZE_W-1:0]  rows_r;
  logic [SIZE_W-1:0]  cols_r;
  logic [CHCNT_W-1:0] chans_r;

  // Position counters
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;

  // Item being worked on
  logic [SAMPLE_W-1:0] sample_r;
  logic [CH_W-1:0]     item_ch_r;
  logic [POS_W-1:0]    item_row_r;
  logic [POS_W-1:0]    item_col_r;
  logic                item_first_r;
  logic                item_last_r;

  // Per-channel stores and their registered read data
  logic [ACC_W-1:0] acc_mem [CHANS_MAX];
  logic [POS_W-1:0] row_mem [CHANS_MAX];
  logic [POS_W-1:0] col_mem [CHANS_MAX];
  logic [ACC_W-1:0] rd_acc_r;
  logic [POS_W-1:0] rd_row_r;
  logic [POS_W-1:0] rd_col_r;

  // Window result and output register
  logic [ACC_W-1:0]       res_acc_r;
  logic [POS_W-1:0]       res_row_r;
  logic [POS_W-1:0]       res_col_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [SIZE_W-1:0]    rows_c;
  logic [SIZE_W-1:0]    cols_c;
  logic [CHCNT_W-1:0]   chans_c;
  logic [CHCNT_W-1:0]   ch_inc;
  logic [SIZE_W-1:0]    col_inc;
  logic [SIZE_W-1:0]    row_inc;
  logic                 first_now;
  logic                 last_now;
  logic [ACC_W-1:0]     s_ext;
  logic                 take;
  logic [ACC_W-1:0]     new_acc;
  logic [POS_W-1:0]     new_row;
  logic [POS_W-1:0]     new_col;
  logic [2*SIZE_W-1:0]  den_full;
  logic                 div_done;
  logic [SAMPLE_W-1:0]  div_q;
  logic [SAMPLE_W-1:0]  pooled;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MEAN;
      rows_r  <= ROWS_RST;
      cols_r  <= COLS_RST;
      chans_r <= CHANS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode_r  <= cfg_data[0];
        CFG_ROWS:  rows_r  <= cfg_data[SIZE_W-1:0];
        CFG_COLS:  cols_r  <= cfg_data[SIZE_W-1:0];
        CFG_CHANS: chans_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes clamped to their legal ranges; zero acts as one.
  always_comb begin
    rows_c  = (rows_r == '0) ? SIZE_W'(1) :
              (rows_r > SIZE_W'(WIN_MAX)) ? SIZE_W'(WIN_MAX) : rows_r;
    cols_c  = (cols_r == '0) ? SIZE_W'(1) :
              (cols_r > SIZE_W'(WIN_MAX)) ? SIZE_W'(WIN_MAX) : cols_r;
    chans_c = (chans_r == '0) ? CHCNT_W'(1) :
              (chans_r > CHCNT_W'(CHANS_MAX)) ? CHCNT_W'(CHANS_MAX) : chans_r;
  end

  // Counter advance: channel innermost, then column, then row.
  always_comb begin
    ch_inc    = {1'b0, ch_r} + 1'b1;
    col_inc   = {1'b0, col_r} + 1'b1;
    row_inc   = {1'b0, row_r} + 1'b1;
    first_now = (row_r == '0) && (col_r == '0);
    last_now  = ({1'b0, row_r} == rows_c - 1'b1) && ({1'b0, col_r} == cols_c - 1'b1);
    ch_nxt    = ch_inc[CH_W-1:0];
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (ch_inc >= chans_c) begin
      ch_nxt  = '0;
      col_nxt = col_inc[POS_W-1:0];
      if (col_inc >= cols_c) begin
        col_nxt = '0;
        row_nxt = row_inc[POS_W-1:0];
        if (row_inc >= rows_c) begin
          row_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      ch_r  <= ch_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Capture the accepted item with its position.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r     <= in_tdata[SAMPLE_W-1:0];
      item_ch_r    <= ch_r;
      item_row_r   <= row_r;
      item_col_r   <= col_r;
      item_first_r <= first_now;
      item_last_r  <= last_now;
    end
  end

  // Read the channel's entry.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_acc_r <= acc_mem[item_ch_r];
      rd_row_r <= row_mem[item_ch_r];
      rd_col_r <= col_mem[item_ch_r];
    end
  end

  // Running sum or running maximum; the first window element overwrites.
  always_comb begin
    s_ext = {{(ACC_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
    take  = item_first_r || ($signed(s_ext) > $signed(rd_acc_r));
    if (mode_r == MODE_MEAN) begin
      new_acc = item_first_r ? s_ext : (rd_acc_r + s_ext);
      new_row = rd_row_r;
      new_col = rd_col_r;
    end else if (take) begin
      new_acc = s_ext;
      new_row = item_row_r;
      new_col = item_col_r;
    end else begin
      new_acc = rd_acc_r;
      new_row = rd_row_r;
      new_col = rd_col_r;
    end
  end

  // Write back the entry and keep it as the window result.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      acc_mem[item_ch_r] <= new_acc;
      row_mem[item_ch_r] <= new_row;
      col_mem[item_ch_r] <= new_col;
      res_acc_r          <= new_acc;
      res_row_r          <= new_row;
      res_col_r          <= new_col;
    end
  end

  // Mean divider, window area as divisor
  assign den_full = {{SIZE_W{1'b0}}, rows_c} * {{SIZE_W{1'b0}}, cols_c};

  wpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (new_acc),
    .divisor  (den_full[DEN_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output field selection
  always_comb begin
    if (mode_r == MODE_MEAN) begin
      pooled  = div_q;
      out_row = '0;
      out_col = '0;
    end else begin
      pooled  = res_acc_r[SAMPLE_W-1:0];
      out_row = res_row_r;
      out_col = res_col_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {{(OUT_TDATA_W-SAMPLE_W-CH_W-2*POS_W){1'b0}},
                     out_col, out_row, item_ch_r, pooled};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller
  assign sts.last     = item_last_r;
  assign sts.mean     = (mode_r == MODE_MEAN);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

/* hw/rtl/wpr_ctrl.sv */
module wpr_ctrl import wpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!sts.last)     state_nxt = ST_IDLE;
        else if (sts.mean) state_nxt = ST_DIV;
        else               state_nxt = ST_OUT;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_UPDATE: begin
        cmd.upd       = 1'b1;
        cmd.div_start = sts.last && sts.mean;
      end
      ST_DIV: ;
      ST_OUT: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/window_pooling_reduce.sv */
// Channel   Direction  Handshake              Payload
// in_       input      in_tvalid/in_tready    in_tdata[15:0] sample
// out_      output     out_tvalid/out_tready  out_tdata pooled_value, channel, max_row, max_col
// cfg_      input      cfg_we (no wait)       cfg_index, cfg_data
//
// An item that does not close a window goes through accept, store read, then update and write.
// Closing a window in max mode adds the step that loads the output register.
// Closing a window in mean mode adds a divide: the serial divider takes one quotient bit a
// cycle over the 24-bit sum, then flags completion, and after that the output register is
// loaded.
// Reset (rst_n low, synchronous) clears the counters, the registers and out_tvalid; the
// channel stores are not cleared and are written by the first element of each window.
// A new item is accepted while a result waits in the output register; a stalled output only
// holds the block when the next result is ready.
module window_pooling_reduce import wpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] pooled_value, [21:16] channel,
                                             // [25:22] max_row, [29:26] max_col
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  wpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wpr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* hw/rtl/wpr_checker.sv */
module wpr_checker import wpr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // After reset the block is ready for an item and shows no result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // An accepted item keeps the input closed while the entry is read and updated.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened before the item was stored");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Padding bits of a shown result stay zero.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:SAMPLE_W+CH_W+2*POS_W] == '0)
    else $error("result padding not zero");

endmodule

bind window_pooling_reduce wpr_checker u_wpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* dv/wpr_pool_checker.sv */
`timescale 1ns / 100ps

// Watches the input, output and configuration ports of the pooling block,
// keeps its own copy of the channel stores and window counters, and compares
// every result item against the oldest pooled value still awaited.
module wpr_pool_checker import wpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  // Result item as packed on out_tdata, highest field first.
  typedef struct packed {
    logic [1:0]                 pad;
    logic [POS_W-1:0]           col;
    logic [POS_W-1:0]           row;
    logic [CH_W-1:0]            ch;
    logic signed [SAMPLE_W-1:0] value;
  } pooled_t;

  // Register copies.
  logic                pool_mode;
  logic [SIZE_W-1:0]   rows_reg;
  logic [SIZE_W-1:0]   cols_reg;
  logic [CHCNT_W-1:0]  chans_reg;

  // Window position and per-channel stores.
  int                       ch_idx;
  int                       col_idx;
  int                       row_idx;
  logic signed [ACC_W-1:0]  acc_mem [CHANS_MAX];
  logic [POS_W-1:0]         peak_row_mem [CHANS_MAX];
  logic [POS_W-1:0]         peak_col_mem [CHANS_MAX];

  pooled_t window_results[$];

  function automatic int eff_size(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic clear_model();
    pool_mode = MODE_MEAN;
    rows_reg  = ROWS_RST;
    cols_reg  = COLS_RST;
    chans_reg = CHANS_RST;
    ch_idx    = 0;
    col_idx   = 0;
    row_idx   = 0;
    for (int i = 0; i < CHANS_MAX; i++) begin
      acc_mem[i]      = '0;
      peak_row_mem[i] = '0;
      peak_col_mem[i] = '0;
    end
    window_results.delete();
  endtask

  // Folds one sample into its channel's entry and queues a result when the
  // sample closes the window.
  task automatic pool_sample(logic signed [SAMPLE_W-1:0] s);
    int                      rows;
    int                      cols;
    int                      chans;
    int                      ch;
    int                      sum;
    logic signed [ACC_W-1:0] s_ext;
    logic                    first;
    logic                    last;
    pooled_t                 res;
    rows  = eff_size(rows_reg, WIN_MAX);
    cols  = eff_size(cols_reg, WIN_MAX);
    chans = eff_size(chans_reg, CHANS_MAX);
    ch    = ch_idx % CHANS_MAX;
    s_ext = {{(ACC_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
    first = (row_idx == 0) && (col_idx == 0);
    last  = (row_idx == rows - 1) && (col_idx == cols - 1);

    // Running sum wraps at the store width; the running maximum keeps the
    // first position on ties.
    if (pool_mode == MODE_MEAN) begin
      acc_mem[ch] = first ? s_ext : acc_mem[ch] + s_ext;
    end else if (first || s_ext > acc_mem[ch]) begin
      acc_mem[ch]      = s_ext;
      peak_row_mem[ch] = POS_W'(row_idx);
      peak_col_mem[ch] = POS_W'(col_idx);
    end

    if (last) begin
      res    = '0;
      res.ch = CH_W'(ch);
      if (pool_mode == MODE_MEAN) begin
        sum       = acc_mem[ch];
        res.value = SAMPLE_W'(sum / (rows * cols));
      end else begin
        res.value = acc_mem[ch][SAMPLE_W-1:0];
        res.row   = peak_row_mem[ch];
        res.col   = peak_col_mem[ch];
      end
      window_results.push_back(res);
    end

    // Channel innermost, then column, then row; a counter past its size
    // wraps on its next step.
    ch_idx++;
    if (ch_idx >= chans) begin
      ch_idx = 0;
      col_idx++;
      if (col_idx >= cols) begin
        col_idx = 0;
        row_idx++;
        if (row_idx >= rows) row_idx = 0;
      end
    end
  endtask

  task automatic check_result(pooled_t got);
    pooled_t want;
    if (window_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result value %0d ch %0d row %0d col %0d",
                 $realtime, got.value, got.ch, got.row, got.col);
    end else begin
      want = window_results.pop_front();
      if (got.value !== want.value || got.ch !== want.ch || got.row !== want.row ||
          got.col !== want.col || got.pad !== want.pad) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch, expected value %0d ch %0d row %0d col %0d pad %0h,",
                    " got value %0d ch %0d row %0d col %0d pad %0h"},
                   $realtime, want.value, want.ch, want.row, want.col, want.pad,
                   got.value, got.ch, got.row, got.col, got.pad);
      end
    end
  endtask

  // Everything is sampled at the rising edge, before the driven values move.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MODE:  pool_mode = cfg_data[0];
          CFG_ROWS:  rows_reg  = cfg_data[SIZE_W-1:0];
          CFG_COLS:  cols_reg  = cfg_data[SIZE_W-1:0];
          CFG_CHANS: chans_reg = cfg_data[CHCNT_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result(pooled_t'(out_tdata));
      if (in_tvalid && in_tready) pool_sample($signed(in_tdata[SAMPLE_W-1:0]));
    end
    pending_count = window_results.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import wpr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_TARGET  = 1400;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [15:0] sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [15:0] pooled_value, [21:16] channel,
                                             // [25:22] max_row, [29:26] max_col
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int fail_count;
  int pending_count;
  int sent_count    = 0;
  int cycle_count   = 0;
  int stall_left    = 0;
  bit in_gaps_on    = 1'b0;
  bit out_stalls_on = 1'b0;

  always #1 clk = ~clk;

  window_pooling_reduce dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wpr_pool_checker pool_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Gap lengths: mostly short, now and then long.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int clamp_size(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Samples lean toward the extremes and small values around zero.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return 16'h7FFF;
    if (r < 6) return 16'h8000;
    if (r < 8) return SAMPLE_W'($urandom_range(0, 8) - 4);
    return SAMPLE_W'($urandom);
  endfunction

  // Register values: mostly small sizes, sometimes zero or past the limit.
  function automatic int pick_size(int hi, int reg_max);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 4);
    if (r == 7) return 0;
    if (r == 8) return $urandom_range(hi + 1, reg_max);
    return $urandom_range(5, hi);
  endfunction

  // Output backpressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = gap_length();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one sample and returns right after the edge that takes it.
  task automatic send_sample(logic [SAMPLE_W-1:0] v);
    int gap;
    gap = 0;
    if (in_gaps_on && $urandom_range(0, 3) == 0) gap = gap_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // Waits until every awaited result has come and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles.
  task automatic configure(logic m, int rows, int cols, int chans);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= CFG_DATA_W'(m);
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_index <= CFG_CHANS;
    cfg_data  <= CFG_DATA_W'(chans);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One setting: whole window sets plus an optional partial window that is
  // left open for the next setting to pick up.
  task automatic run_phase(logic m, int rows, int cols, int chans, int sets, int tail);
    int n;
    n = clamp_size(rows, WIN_MAX) * clamp_size(cols, WIN_MAX) *
        clamp_size(chans, CHANS_MAX) * sets + tail;
    in_gaps_on    = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
    configure(m, rows, cols, chans);
    repeat (n) send_sample(pick_sample());
    settle();
  endtask

  initial begin
    logic m;
    int   rows;
    int   cols;
    int   chans;
    int   win;
    int   sets;
    int   tail;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting, mean of 2x2 on one channel: largest and smallest sums,
    // then a negative sum that must truncate toward zero.
    repeat (4) send_sample(16'h7FFF);
    repeat (4) send_sample(16'h8000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'hFFFE);
    send_sample(16'h0000);
    settle();

    // Max of 2x2: all equal, maximum at the last position, tie after the peak.
    configure(MODE_MAX, 2, 2, 1);
    repeat (4) send_sample(16'd5);
    repeat (3) send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'd7);
    send_sample(16'd9);
    send_sample(16'd9);
    send_sample(16'd1);
    settle();

    // Max mode over all channels at once fills every channel store, so later
    // mid-window setting changes only ever read written entries.
    run_phase(MODE_MAX, 1, 1, CHANS_MAX, 1, 0);
    run_phase(MODE_MEAN, WIN_MAX, WIN_MAX, 1, 1, 0);
    run_phase(MODE_MAX, 31, 0, 3, 1, 0);
    run_phase(MODE_MAX, 1, WIN_MAX, 2, 1, 5);
    run_phase(MODE_MEAN, 0, 0, 0, 8, 0);
    run_phase(MODE_MEAN, 1, 1, 127, 1, 0);

    // Random settings with random window content.
    while (sent_count < ITEM_TARGET) begin
      m     = $urandom_range(0, 1);
      rows  = pick_size(WIN_MAX, 31);
      cols  = pick_size(WIN_MAX, 31);
      chans = pick_size(CHANS_MAX, 127);
      win   = clamp_size(rows, WIN_MAX) * clamp_size(cols, WIN_MAX) *
              clamp_size(chans, CHANS_MAX);
      while (win > 192) begin
        chans = $urandom_range(1, 4);
        rows  = $urandom_range(1, 4);
        win   = clamp_size(rows, WIN_MAX) * clamp_size(cols, WIN_MAX) * chans;
      end
      sets = $urandom_range(1, (64 / win > 1) ? 64 / win : 1);
      tail = (win > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, win - 1) : 0;
      run_phase(m, rows, cols, chans, sets, tail);
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wpr_pkg.sv
hw/rtl/wpr_div.sv
hw/rtl/wpr_dp.sv
hw/rtl/wpr_ctrl.sv
hw/rtl/window_pooling_reduce.sv
hw/rtl/wpr_checker.sv
dv/wpr_pool_checker.sv
dv/testbench.sv
